// ===== src/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// assertion helpers, all clocked on clk and quiet while arst_n is low

// condition holds at every edge
`define ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

// ===== src/bcpg_pkg.sv =====
`default_nettype none

package bcpg_pkg;

	// field widths
	localparam int SEG_W     = 6;
	localparam int COORD_W   = 16;
	localparam int CFG_IDX_W = 3;
	localparam int MAX_PTS   = 4;
	localparam int U_W       = 17;

	// 1.0 in unsigned Q1.16
	localparam logic [U_W-1:0] UNIT_U = 17'h10000;
	// quotient bits of 2^16 / segments
	localparam logic [4:0] DIV_STEPS = 5'd17;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
	} point_t;

	// microprogram steps
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV,
		ST_PT_INIT,
		ST_TERM_INIT,
		ST_POW,
		ST_WEIGHT,
		ST_MAC_X,
		ST_MAC_Y,
		ST_OUT_WAIT,
		ST_EMIT,
		ST_DONE
	} step_t;

	// datapath operations
	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_DIV,
		OP_PT_INIT,
		OP_TERM_INIT,
		OP_POW,
		OP_WEIGHT,
		OP_MAC_X,
		OP_MAC_Y,
		OP_EMIT
	} dp_op_t;

	// jump conditions
	typedef enum logic [2:0] {
		CD_NEXT,
		CD_ALWAYS,
		CD_NO_REQ,
		CD_DIV_MORE,
		CD_POW_MORE,
		CD_TERM_MORE,
		CD_OUT_BUSY,
		CD_MORE_PTS
	} cond_t;

	typedef struct packed {
		dp_op_t op;
		cond_t  cond;
		step_t  target;
	} ctrl_word_t;

	typedef struct packed {
		logic div_more;
		logic pow_more;
		logic term_more;
		logic out_busy;
		logic last_pt;
	} dp_status_t;

	// microcode rom
	function automatic ctrl_word_t ctrl_rom(input step_t s);
		ctrl_word_t w;
		case (s)
			ST_IDLE:      w = '{op: OP_LOAD,      cond: CD_NO_REQ,    target: ST_IDLE};
			ST_DIV:       w = '{op: OP_DIV,       cond: CD_DIV_MORE,  target: ST_DIV};
			ST_PT_INIT:   w = '{op: OP_PT_INIT,   cond: CD_NEXT,      target: ST_IDLE};
			ST_TERM_INIT: w = '{op: OP_TERM_INIT, cond: CD_NEXT,      target: ST_IDLE};
			ST_POW:       w = '{op: OP_POW,       cond: CD_POW_MORE,  target: ST_POW};
			ST_WEIGHT:    w = '{op: OP_WEIGHT,    cond: CD_NEXT,      target: ST_IDLE};
			ST_MAC_X:     w = '{op: OP_MAC_X,     cond: CD_NEXT,      target: ST_IDLE};
			ST_MAC_Y:     w = '{op: OP_MAC_Y,     cond: CD_TERM_MORE, target: ST_TERM_INIT};
			ST_OUT_WAIT:  w = '{op: OP_NONE,      cond: CD_OUT_BUSY,  target: ST_OUT_WAIT};
			ST_EMIT:      w = '{op: OP_EMIT,      cond: CD_MORE_PTS,  target: ST_PT_INIT};
			ST_DONE:      w = '{op: OP_NONE,      cond: CD_ALWAYS,    target: ST_IDLE};
			default:      w = '{op: OP_NONE,      cond: CD_ALWAYS,    target: ST_IDLE};
		endcase
		return w;
	endfunction

	// binomial coefficient C(n,i) for n up to 3
	function automatic logic [1:0] binom(input logic [1:0] n, input logic [1:0] i);
		logic [1:0] b;
		b = 2'd1;
		if (n == 2'd3 && (i == 2'd1 || i == 2'd2))
			b = 2'd3;
		else if (n == 2'd2 && i == 2'd1)
			b = 2'd2;
		return b;
	endfunction

	// control point register reset values
	function automatic point_t pt_reset(input logic [1:0] idx);
		point_t p;
		case (idx)
			2'd0:    p = '{x: 16'sd1280, y: 16'sd6400};
			2'd1:    p = '{x: 16'sd1920, y: 16'sd7040};
			2'd2:    p = '{x: 16'sd3200, y: 16'sd5760};
			2'd3:    p = '{x: 16'sd3840, y: 16'sd6400};
			default: p = '{x: 16'sd0, y: 16'sd0};
		endcase
		return p;
	endfunction

endpackage

`default_nettype wire

// ===== src/bcpg_if.sv =====
`default_nettype none

// curve request channel
interface bcpg_req_if;
	import bcpg_pkg::*;
	logic             valid;
	logic             ready;
	logic [SEG_W-1:0] segments;
	modport source(output valid, output segments, input ready);
	modport sink(input valid, input segments, output ready);
endinterface

// curve point channel
interface bcpg_pt_if;
	import bcpg_pkg::*;
	logic                      valid;
	logic                      ready;
	logic [SEG_W-1:0]          step_index;
	logic signed [COORD_W-1:0] x_coord;
	logic signed [COORD_W-1:0] y_coord;
	logic                      last;
	modport source(output valid, output step_index, output x_coord, output y_coord,
		output last, input ready);
	modport sink(input valid, input step_index, input x_coord, input y_coord,
		input last, output ready);
endinterface

`default_nettype wire

// ===== src/bcpg_seq.sv =====
`default_nettype none

module bcpg_seq (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     req_valid,
	output logic                    req_ready,
	input  wire bcpg_pkg::dp_status_t stat,
	output bcpg_pkg::dp_op_t        op
);
	import bcpg_pkg::*;

	step_t      upc_q;
	step_t      upc_d;
	ctrl_word_t cw;
	logic       jump;

	// control word of the current step
	always_comb begin
		cw        = ctrl_rom(upc_q);
		op        = cw.op;
		req_ready = (cw.op == OP_LOAD);
	end

	// next step: jump target or fall through
	always_comb begin
		case (cw.cond)
			CD_NEXT:      jump = 1'b0;
			CD_ALWAYS:    jump = 1'b1;
			CD_NO_REQ:    jump = !req_valid;
			CD_DIV_MORE:  jump = stat.div_more;
			CD_POW_MORE:  jump = stat.pow_more;
			CD_TERM_MORE: jump = stat.term_more;
			CD_OUT_BUSY:  jump = stat.out_busy;
			CD_MORE_PTS:  jump = !stat.last_pt;
			default:      jump = 1'b1;
		endcase
		if (jump)
			upc_d = cw.target;
		else
			upc_d = step_t'(4'(upc_q) + 4'd1);
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			upc_q <= ST_IDLE;
		else
			upc_q <= upc_d;
	end

endmodule

`default_nettype wire

// ===== src/bcpg_dp.sv =====
`default_nettype none

module bcpg_dp #(
	parameter int NUM_POINTS = 4
) (
	input  wire                                         clk,
	input  wire                                         arst_n,
	input  wire bcpg_pkg::dp_op_t                       op,
	input  wire                                         req_fire,
	input  wire [bcpg_pkg::SEG_W-1:0]                   req_segments,
	input  wire bcpg_pkg::point_t [bcpg_pkg::MAX_PTS-1:0] pts,
	output bcpg_pkg::dp_status_t                        stat,
	bcpg_pt_if.source                                   pt
);
	import bcpg_pkg::*;

	localparam int ORDER = NUM_POINTS - 1;
	localparam int IW    = (NUM_POINTS > 2) ? 2 : 1;

	`include "assert_macros.svh"

	// request and parameter state
	logic [SEG_W-1:0]   seg_q;
	logic [SEG_W-1:0]   k_q;
	logic [U_W-1:0]     u_q;
	logic [SEG_W-1:0]   frac_q;
	logic [U_W-1:0]     q0_q;
	logic [SEG_W-1:0]   dv_rem_q;
	logic [4:0]         div_cnt_q;
	// per point work registers
	logic [IW-1:0]      i_q;
	logic [1:0]         j_q;
	logic [48:0]        pw_q;
	logic [32:0]        wt_q;
	logic signed [COORD_W-1:0] pc_x_q;
	logic signed [COORD_W-1:0] pc_y_q;
	logic signed [49:0] acc_x_q;
	logic signed [49:0] acc_y_q;
	// output register
	logic               valid_q;
	logic [SEG_W-1:0]   step_q;
	logic signed [COORD_W-1:0] x_q;
	logic signed [COORD_W-1:0] y_q;
	logic               last_q;

	logic [1:0]         i_ext;
	logic [U_W-1:0]     v;
	logic [U_W-1:0]     fac;
	logic [49:0]        pow_prod;
	logic [1:0]         bc;
	logic [49:0]        bw;
	logic [32:0]        wt_d;
	logic signed [33:0] wt_s;
	logic signed [49:0] mac_x;
	logic signed [49:0] mac_y;
	logic [6:0]         trial;
	logic               div_ge;
	logic               div_qbit;
	logic [SEG_W-1:0]   div_rem_d;
	logic [6:0]         fsum;
	logic               carry;
	logic [SEG_W-1:0]   frac_next;
	logic [U_W-1:0]     u_next;
	logic               last_pt;

	function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [17:0] a);
		logic signed [COORD_W-1:0] r;
		if (a > 18'sd32767)
			r = 16'sh7fff;
		else if (a < -18'sd32768)
			r = -16'sh8000;
		else
			r = a[15:0];
		return r;
	endfunction

	// restoring division of 2^16 by the segment count, one bit a step
	always_comb begin
		div_qbit  = 1'b0;
		trial     = {dv_rem_q, (div_cnt_q == DIV_STEPS)};
		div_ge    = trial >= {1'b0, seg_q};
		div_rem_d = trial[5:0];
		if (div_ge) begin
			div_qbit  = 1'b1;
			div_rem_d = 6'(trial - {1'b0, seg_q});
		end
	end

	// next parameter u: add quotient, carry the remainder
	always_comb begin
		fsum      = {1'b0, frac_q} + {1'b0, dv_rem_q};
		carry     = fsum >= {1'b0, seg_q};
		frac_next = carry ? 6'(fsum - {1'b0, seg_q}) : fsum[5:0];
		u_next    = u_q + q0_q + {16'b0, carry};
	end

	// power chain and bernstein weight
	always_comb begin
		i_ext    = 2'(i_q);
		v        = UNIT_U - u_q;
		fac      = (j_q < i_ext) ? u_q : v;
		pow_prod = pw_q[32:0] * fac;
		bc       = binom(2'(ORDER), i_ext);
		bw       = (bc[0] ? {1'b0, pw_q} : 50'd0) + (bc[1] ? {pw_q, 1'b0} : 50'd0);
		if (ORDER == 3)
			wt_d = bw[48:16];
		else if (ORDER == 2)
			wt_d = bw[32:0];
		else
			wt_d = {bw[16:0], 16'b0};
	end

	// weight times control point
	always_comb begin
		wt_s  = {1'b0, wt_q};
		mac_x = wt_s * pc_x_q;
		mac_y = wt_s * pc_y_q;
	end

	assign last_pt = (k_q == seg_q);

	// status to the sequencer
	always_comb begin
		stat.div_more  = (div_cnt_q != 5'd1);
		stat.pow_more  = (j_q != 2'(ORDER - 1));
		stat.term_more = (i_q != IW'(NUM_POINTS - 1));
		stat.out_busy  = valid_q && !pt.ready;
		stat.last_pt   = last_pt;
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (op)
			OP_LOAD: begin
				if (req_fire) begin
					seg_q     <= req_segments;
					k_q       <= '0;
					u_q       <= '0;
					frac_q    <= '0;
					q0_q      <= '0;
					dv_rem_q  <= '0;
					div_cnt_q <= DIV_STEPS;
				end
			end
			OP_DIV: begin
				dv_rem_q  <= div_rem_d;
				q0_q      <= {q0_q[U_W-2:0], div_qbit};
				div_cnt_q <= div_cnt_q - 5'd1;
			end
			OP_PT_INIT: begin
				acc_x_q <= '0;
				acc_y_q <= '0;
				i_q     <= '0;
			end
			OP_TERM_INIT: begin
				pw_q <= 49'd1;
				j_q  <= '0;
			end
			OP_POW: begin
				pw_q <= pow_prod[48:0];
				j_q  <= j_q + 2'd1;
			end
			OP_WEIGHT: begin
				wt_q   <= wt_d;
				pc_x_q <= pts[i_ext].x;
				pc_y_q <= pts[i_ext].y;
			end
			OP_MAC_X: acc_x_q <= acc_x_q + mac_x;
			OP_MAC_Y: begin
				acc_y_q <= acc_y_q + mac_y;
				i_q     <= i_q + IW'(1);
			end
			OP_EMIT: begin
				k_q    <= k_q + 6'd1;
				u_q    <= u_next;
				frac_q <= frac_next;
				step_q <= k_q;
				x_q    <= sat_coord(acc_x_q[49:32]);
				y_q    <= sat_coord(acc_y_q[49:32]);
				last_q <= last_pt;
			end
			default: ;
		endcase
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (op == OP_EMIT)
			valid_q <= 1'b1;
		else if (pt.ready)
			valid_q <= 1'b0;
	end

	assign pt.valid      = valid_q;
	assign pt.step_index = step_q;
	assign pt.x_coord    = x_q;
	assign pt.y_coord    = y_q;
	assign pt.last       = last_q;

	// checks
	`ASSERT_IMPLIES(a_emit_into_free_reg, op == OP_EMIT, !(valid_q && !pt.ready), "point overwrites a waiting transaction")
	`ASSERT_IMPLIES(a_end_param_is_one, (op == OP_PT_INIT) && last_pt && (seg_q != '0), u_q == UNIT_U, "u of the final point is not 1.0")
	`ASSERT_IMPLIES(a_frac_below_seg, (op == OP_EMIT) && (seg_q != '0), frac_q < seg_q, "u remainder out of range")

endmodule

`default_nettype wire

// ===== src/bezier_curve_point_generator_top.sv =====
`default_nettype none

// channel   dir  handshake      payload
// req       in   valid/ready    segments[5:0]
// pt        out  valid/ready    step_index[5:0] x_coord[15:0] y_coord[15:0] last
// cfg       in   cfg_we         cfg_idx[2:0] cfg_wdata[15:0]
//
// a request runs the idle step, 17 bit-serial divider steps and done step,
// then per point the single shared power multiplier and the x and y macs,
// all stepped by the microprogram.
// one request is taken at a time; req.ready is high only in the idle step.
// a stalled pt.ready holds the sequencer before it writes the next point.
// arst_n clears the step counter and output valid and loads the control point reset values.

module bezier_curve_point_generator_top #(
	parameter int NUM_POINTS = 4
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                cfg_we,
	input  wire [bcpg_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  wire [bcpg_pkg::COORD_W-1:0]        cfg_wdata,
	bcpg_req_if.sink                           req,
	bcpg_pt_if.source                          pt
);
	import bcpg_pkg::*;

	point_t [MAX_PTS-1:0] pts_q;
	dp_status_t           stat;
	dp_op_t               op;
	logic                 req_ready;

	// control point registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < MAX_PTS; p++)
				pts_q[p] <= pt_reset(2'(p));
		end else if (cfg_we) begin
			if (cfg_idx[0])
				pts_q[cfg_idx[2:1]].y <= cfg_wdata;
			else
				pts_q[cfg_idx[2:1]].x <= cfg_wdata;
		end
	end

	assign req.ready = req_ready;

	// microprogram sequencer
	bcpg_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req_ready),
		.stat      (stat),
		.op        (op)
	);

	// arithmetic datapath
	bcpg_dp #(
		.NUM_POINTS (NUM_POINTS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.op           (op),
		.req_fire     (req.valid && req_ready),
		.req_segments (req.segments),
		.pts          (pts_q),
		.stat         (stat),
		.pt           (pt)
	);

endmodule

`default_nettype wire
